// File: sv/snuv_pkg.sv
package snuv_pkg;

	localparam int TABLE_LEN = 24;
	localparam int ZW = 34;
	localparam int XW = 40;
	localparam int ONE_Q14 = 16384;
	localparam logic signed [ZW-1:0] HALF_TURN = 34'sh080000000;

	typedef logic signed [ZW-1:0] angle_t;
	typedef logic signed [XW-1:0] vec_t;

	// cordic lane contents between stages
	typedef struct packed {
		vec_t x;
		vec_t y;
		angle_t z;
		logic flip;
		logic ypos;
		logic yzero;
		logic xneg;
	} lane_t;

	function automatic angle_t atan_entry(input logic [4:0] i);
		case (i)
			5'd0: atan_entry = 34'sh020000000;
			5'd1: atan_entry = 34'sh012E4051E;
			5'd2: atan_entry = 34'sh009FB385B;
			5'd3: atan_entry = 34'sh0051111D4;
			5'd4: atan_entry = 34'sh0028B0D43;
			5'd5: atan_entry = 34'sh00145D7E1;
			5'd6: atan_entry = 34'sh000A2F61E;
			5'd7: atan_entry = 34'sh000517C55;
			5'd8: atan_entry = 34'sh00028BE53;
			5'd9: atan_entry = 34'sh000145F2F;
			5'd10: atan_entry = 34'sh0000A2F98;
			5'd11: atan_entry = 34'sh0000517CC;
			5'd12: atan_entry = 34'sh000028BE6;
			5'd13: atan_entry = 34'sh0000145F3;
			5'd14: atan_entry = 34'sh00000A2FA;
			5'd15: atan_entry = 34'sh00000517D;
			5'd16: atan_entry = 34'sh0000028BE;
			5'd17: atan_entry = 34'sh00000145F;
			5'd18: atan_entry = 34'sh000000A30;
			5'd19: atan_entry = 34'sh000000518;
			5'd20: atan_entry = 34'sh00000028C;
			5'd21: atan_entry = 34'sh000000146;
			5'd22: atan_entry = 34'sh0000000A3;
			5'd23: atan_entry = 34'sh000000051;
			default: atan_entry = '0;
		endcase
	endfunction

	// prepare a cordic lane from a signed pair
	function automatic lane_t lane_init(input logic signed [17:0] y, input logic signed [17:0] x);
		lane_t l;
		logic signed [17:0] ax;
		logic signed [17:0] ay;
		l.xneg = x < 0;
		l.ypos = y > 0;
		l.yzero = y == 0;
		l.flip = x < 0;
		ax = l.flip ? -x : x;
		ay = l.flip ? -y : y;
		l.x = {{(XW-34){ax[17]}}, ax, 16'd0};
		l.y = {{(XW-34){ay[17]}}, ay, 16'd0};
		l.z = '0;
		return l;
	endfunction

	// one vectoring rotation
	function automatic lane_t lane_step(input lane_t l, input logic [4:0] i);
		lane_t r;
		vec_t dx;
		vec_t dy;
		r = l;
		dx = l.y >>> i;
		dy = l.x >>> i;
		if (l.y > 0) begin
			r.x = l.x + dx;
			r.y = l.y - dy;
			r.z = l.z + atan_entry(i);
		end else begin
			r.x = l.x - dx;
			r.y = l.y + dy;
			r.z = l.z - atan_entry(i);
		end
		return r;
	endfunction

	// quadrant fixup and clamps
	function automatic angle_t lane_final(input lane_t l);
		angle_t z;
		if (l.yzero) begin
			z = l.xneg ? HALF_TURN : '0;
		end else begin
			z = l.z;
			if (l.flip) z = l.ypos ? z + HALF_TURN : z - HALF_TURN;
			if (l.ypos) begin
				if (z < 0) z = '0;
				if (z > HALF_TURN) z = HALF_TURN;
			end else begin
				if (z > 0) z = '0;
				if (z < -HALF_TURN) z = -HALF_TURN;
			end
		end
		return z;
	endfunction

endpackage

// File: sv/snuv_sqrt.sv
// pipelined integer square root of 2^28 - ny^2, one result bit per stage
module snuv_sqrt (
	input logic clk,
	input logic en,
	input logic [28:0] n_in,
	output logic [14:0] root
);
	localparam int ST = 15;

	logic [28:0] rem_s [ST+1];
	logic [14:0] res_s [ST+1];

	assign rem_s[0] = n_in;
	assign res_s[0] = '0;

	// restoring digit recurrence, one registered stage per bit
	for (genvar k = 0; k < ST; k++) begin : g_st
		localparam int B = ST - 1 - k;
		logic [29:0] trial;
		logic [29:0] rem_w;
		logic [28:0] rem_r;
		logic [14:0] res_r;
		assign trial = {15'd0, res_s[k]} << (B + 1);
		assign rem_w = {1'b0, rem_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_w >= trial + (30'd1 << (2 * B))) begin
					rem_r <= 29'(rem_w - trial - (30'd1 << (2 * B)));
					res_r <= res_s[k] | (15'd1 << B);
				end else begin
					rem_r <= rem_s[k];
					res_r <= res_s[k];
				end
			end
		end
		assign rem_s[k+1] = rem_r;
		assign res_s[k+1] = res_r;
	end

	assign root = res_s[ST];
endmodule

// File: sv/snuv_cordic.sv
// vectoring cordic, one rotation per registered stage
module snuv_cordic #(
	parameter int STEPS = 16
) (
	input logic clk,
	input logic en,
	input snuv_pkg::lane_t lane_in,
	output snuv_pkg::angle_t angle
);
	import snuv_pkg::*;

	localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

	lane_t lane_s [N+1];
	angle_t angle_q;

	assign lane_s[0] = lane_in;

	for (genvar i = 0; i < N; i++) begin : g_rot
		lane_t r;
		always_ff @(posedge clk) begin
			if (en) r <= lane_step(lane_s[i], 5'(i));
		end
		assign lane_s[i+1] = r;
	end

	// final fixup stage
	always_ff @(posedge clk) begin
		if (en) angle_q <= lane_final(lane_s[N]);
	end

	assign angle = angle_q;
endmodule

// File: sv/sphere_normal_to_uv.sv
// sphere_normal_to_uv: equirectangular texture coordinates from a unit normal
// s_axis_tdata carries one normal per request, m_axis_tdata one (u, v) pair.
// the pipeline is fully stalled when m_axis_tready is low and the last stage
// holds a result; s_axis_tready follows that, so nothing is lost or repeated.
// while not stalled an item enters every cycle, throughput one request per clock.
// stages: 1 input stage, 15 square root stages, CORDIC_STEPS (max 24)
// rotation stages, 1 fixup stage and 1 output stage; the u path is delayed
// to match the v path, whose square root sets the depth.
// reset clears all valid bits; payload registers are not reset.
module sphere_normal_to_uv #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [47:0] s_axis_tdata, // normal_x, normal_y, normal_z
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata // tex_u[15:0], tex_v[32:16], zero pad
);
	import snuv_pkg::*;

	localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int DEPTH = 1 + 15 + N + 1;
	localparam int UDLY = 15;

	logic en;
	logic [DEPTH-1:0] vld_q;
	logic out_vld_q;
	logic [15:0] u_q;
	logic [16:0] v_q;

	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// valid bits march with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
			out_vld_q <= vld_q[DEPTH-1];
		end
	end

	// input stage: clamp ny and square it
	logic signed [15:0] nx, ny, nz;
	logic signed [15:0] ny_c;
	logic signed [15:0] ny_s1, nx_s1, nz_s1;
	logic [28:0] n_s1;
	assign nx = s_axis_tdata[15:0];
	assign ny = s_axis_tdata[31:16];
	assign nz = s_axis_tdata[47:32];
	always_comb begin
		ny_c = ny;
		if (ny > 16'sd16384) ny_c = 16'sd16384;
		if (ny < -16'sd16384) ny_c = -16'sd16384;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ny_s1 <= ny_c;
			nx_s1 <= nx;
			nz_s1 <= nz;
			n_s1 <= 29'(32'sd268435456 - 32'(ny_c) * 32'(ny_c));
		end
	end

	// v path: square root then cordic
	logic [14:0] root;
	logic signed [15:0] ny_d [UDLY+1];
	snuv_sqrt u_sqrt (.clk(clk), .en(en), .n_in(n_s1), .root(root));

	// u path and ny delay to line up with the square root
	logic signed [15:0] nx_d [UDLY+1];
	logic signed [15:0] nz_d [UDLY+1];
	assign nx_d[0] = nx_s1;
	assign nz_d[0] = nz_s1;
	assign ny_d[0] = ny_s1;
	for (genvar k = 0; k < UDLY; k++) begin : g_dly
		logic signed [15:0] a, b, c;
		always_ff @(posedge clk) begin
			if (en) begin
				a <= nx_d[k];
				b <= nz_d[k];
				c <= ny_d[k];
			end
		end
		assign nx_d[k+1] = a;
		assign nz_d[k+1] = b;
		assign ny_d[k+1] = c;
	end

	lane_t lane_v, lane_u;
	angle_t phi, zu;
	logic degen_d [N+2];
	assign lane_v = lane_init(18'(ny_d[UDLY]), {3'd0, root});
	assign lane_u = lane_init(18'(nx_d[UDLY]), -18'(nz_d[UDLY]));

	snuv_cordic #(.STEPS(N)) u_cv (.clk(clk), .en(en), .lane_in(lane_v), .angle(phi));
	snuv_cordic #(.STEPS(N)) u_cu (.clk(clk), .en(en), .lane_in(lane_u), .angle(zu));

	assign degen_d[0] = (nx_d[UDLY] == 0) && (nz_d[UDLY] == 0);
	for (genvar k = 0; k <= N; k++) begin : g_dg
		logic d;
		always_ff @(posedge clk) begin
			if (en) d <= degen_d[k];
		end
		assign degen_d[k+1] = d;
	end

	// output stage: scale and round
	logic signed [ZW:0] ut, vt;
	logic [15:0] u_c;
	logic [16:0] v_c;
	always_comb begin
		ut = (35'(HALF_TURN) - 35'(zu) + 35'sd32768) >>> 16;
		vt = 35'sd32768 + ((35'(phi) + 35'sd16384) >>> 15);
		if (degen_d[N+1]) u_c = 16'd32768;
		else if (ut > 35'sd65535) u_c = 16'hFFFF;
		else if (ut < 0) u_c = '0;
		else u_c = ut[15:0];
		if (vt < 0) v_c = '0;
		else if (vt > 35'sd65536) v_c = 17'd65536;
		else v_c = vt[16:0];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			u_q <= u_c;
			v_q <= v_c;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {7'd0, v_q, u_q};

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// v never exceeds one
	a_vmax: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[32:16] <= 17'd65536)
		else $error("tex_v out of range");
	// no intake while output stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("accepted under stall");
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int STEPS = 16;
	localparam int LATENCY = 18 + STEPS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 950;
	localparam logic signed [63:0] HALF = 64'sd2147483648;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;

	typedef struct packed {
		logic [15:0] u;
		logic [16:0] v;
	} uv_t;

	// directed request with optional typed-in expectation
	typedef struct {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		bit fixed;
		logic [15:0] u;
		logic [16:0] v;
	} row_t;

	uv_t uv_queue[$];
	int mismatches = 0;
	int idle_ctr = 0;
	bit quiet;

	sphere_normal_to_uv #(.CORDIC_STEPS(STEPS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [63:0] arctan_step(input int i);
		logic signed [63:0] t [24];
		t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
		return t[i];
	endfunction

	// binary angle of (x, y), full turn 2^32
	function automatic logic signed [63:0] binary_angle(input logic signed [63:0] y_in,
			input logic signed [63:0] x_in);
		logic signed [63:0] x, y, z, dx, dy;
		bit flip;
		if (y_in == 0)
			return (x_in < 0) ? HALF : 64'sd0;
		flip = x_in < 0;
		x = (flip ? -x_in : x_in) * 65536;
		y = (flip ? -y_in : y_in) * 65536;
		z = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_step(i);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_step(i);
			end
		end
		if (flip) z = (y_in > 0) ? z + HALF : z - HALF;
		if (y_in > 0) begin
			if (z < 0) z = 0;
			if (z > HALF) z = HALF;
		end else begin
			if (z > 0) z = 0;
			if (z < -HALF) z = -HALF;
		end
		return z;
	endfunction

	function automatic longint floor_sqrt(input longint n);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		return r;
	endfunction

	// texture coordinates of one normal
	function automatic uv_t normal_to_uv(input logic [15:0] nx_b, input logic [15:0] ny_b,
			input logic [15:0] nz_b);
		logic signed [63:0] nx, ny, nz, phi, vv, uu;
		uv_t r;
		nx = $signed(nx_b);
		ny = $signed(ny_b);
		nz = $signed(nz_b);
		if (ny > 16384) ny = 16384;
		if (ny < -16384) ny = -16384;
		phi = binary_angle(ny, floor_sqrt(64'sd268435456 - ny * ny));
		vv = 32768 + ((phi + 16384) >>> 15);
		if (vv < 0) vv = 0;
		if (vv > 65536) vv = 65536;
		if (nx == 0 && nz == 0) begin
			uu = 32768;
		end else begin
			uu = (HALF - binary_angle(nx, -nz) + 32768) >>> 16;
			if (uu > 65535) uu = 65535;
			if (uu < 0) uu = 0;
		end
		r.u = uu[15:0];
		r.v = vv[16:0];
		return r;
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 38);
	endfunction

	task automatic send_normal(input logic [15:0] nx, input logic [15:0] ny,
			input logic [15:0] nz, input bit fixed, input uv_t want);
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {nz, ny, nx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		uv_queue.push_back(fixed ? want : normal_to_uv(nx, ny, nz));
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_component();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'($urandom_range(32));
			2: return -16'($urandom_range(32));
			default: return 16'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// result side: stall and check
	always @(negedge clk) begin
		m_axis_tready <= !idle_now();
	end

	always @(posedge clk) begin
		uv_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.u = m_axis_tdata[15:0];
			got.v = m_axis_tdata[32:16];
			if (uv_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result u=%0d v=%0d", got.u, got.v);
			end else begin
				want = uv_queue.pop_front();
				if (got.u !== want.u || got.v !== want.v || m_axis_tdata[39:33] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: u exp %0d got %0d, v exp %0d got %0d",
							want.u, got.u, want.v, got.v);
				end
			end
		end
	end

	// watchdog on cycles without any request or result moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_ctr <= 0;
		else
			idle_ctr <= idle_ctr + 1;
		if (idle_ctr >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	row_t rows[$];

	initial begin
		uv_t want;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		// zero vector: u centered, v at the equator
		rows.push_back('{16'd0, 16'd0, 16'd0, 1, 16'd32768, 17'd32768});
		// poles, clamping of ny past unit range
		rows.push_back('{16'd0, 16'd16384, 16'd0, 0, 0, 0});
		rows.push_back('{16'd0, -16'sd16384, 16'd0, 0, 0, 0});
		rows.push_back('{16'd0, 16'h7fff, 16'd0, 0, 0, 0});
		rows.push_back('{16'd0, 16'h8000, 16'd0, 0, 0, 0});
		// zero azimuth along -z, half turn along +z (u is 0 there)
		rows.push_back('{16'd0, 16'd0, -16'sd16384, 1, 16'd32768, 17'd32768});
		rows.push_back('{16'd0, 16'd0, 16'd16384, 1, 16'd0, 17'd32768});
		rows.push_back('{16'd16384, 16'd0, 16'd0, 0, 0, 0});
		rows.push_back('{-16'sd16384, 16'd0, 16'd0, 0, 0, 0});
		rows.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0});
		rows.push_back('{16'h8000, 16'h8000, 16'h8000, 0, 0, 0});
		rows.push_back('{16'h8000, 16'd1, 16'h7fff, 0, 0, 0});
		rows.push_back('{16'hffff, 16'hffff, 16'hffff, 0, 0, 0});
		rows.push_back('{16'd1, 16'd1, 16'd16384, 0, 0, 0});
		rows.push_back('{-16'sd1, 16'd1, 16'd16384, 0, 0, 0});
		rows.push_back('{16'd11585, 16'd8192, -16'sd11585, 0, 0, 0});
		rows.push_back('{-16'sd11585, -16'sd8192, 16'd11585, 0, 0, 0});
		rows.push_back('{16'h5555, 16'haaaa, 16'h5555, 0, 0, 0});
		rows.push_back('{16'haaaa, 16'h5555, 16'haaaa, 0, 0, 0});
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[k]) begin
			want.u = rows[k].u;
			want.v = rows[k].v;
			send_normal(rows[k].nx, rows[k].ny, rows[k].nz, rows[k].fixed, want);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// a stretch with back-to-back traffic on both sides
			quiet = (n >= 300 && n < 450);
			send_normal(rand_component(), rand_component(), rand_component(), 0, want);
		end
		quiet = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (uv_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && uv_queue.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: sim.f
sv/snuv_pkg.sv
sv/snuv_sqrt.sv
sv/snuv_cordic.sv
sv/sphere_normal_to_uv.sv
sim/tb_top.sv
